@@ rtl/tpr_pkg.sv @@
// Package for the typographic punctuation rewriter.
// Holds mark and token codes, the plan struct and the token spelling functions.
// No dependencies.
package tpr_pkg;

    typedef logic [2:0] held_t;
    typedef logic [3:0] tok_t;
    typedef logic [1:0] mode_t;

    localparam held_t HELD_NONE = 3'd0;
    localparam held_t HELD_D1   = 3'd1;
    localparam held_t HELD_D2   = 3'd2;
    localparam held_t HELD_B1   = 3'd3;
    localparam held_t HELD_A1   = 3'd4;

    localparam mode_t MODE_ASCII = 2'd0;
    localparam mode_t MODE_UTF8  = 2'd1;
    localparam mode_t MODE_HTML  = 2'd2;
    localparam mode_t MODE_PASS  = 2'd3;

    localparam tok_t TOK_NONE = 4'd0;
    localparam tok_t TOK_EM   = 4'd1;
    localparam tok_t TOK_EN   = 4'd2;
    localparam tok_t TOK_LDQ  = 4'd3;
    localparam tok_t TOK_LSQ  = 4'd4;
    localparam tok_t TOK_RDQ  = 4'd5;
    localparam tok_t TOK_RSQ  = 4'd6;
    localparam tok_t TOK_DASH = 4'd7;  // single '-' in every mode
    localparam tok_t TOK_RAW2 = 4'd8;  // raw "--"
    localparam tok_t TOK_BQ   = 4'd9;  // raw '`'
    localparam tok_t TOK_AP   = 4'd10; // raw apostrophe
    localparam tok_t TOK_LIT  = 4'd11; // the input byte itself

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_BQ   = 8'h60;
    localparam logic [7:0] CH_AP   = 8'h27;
    localparam logic [7:0] CH_DQ   = 8'h22;

    typedef struct packed {
        tok_t tok1;
        tok_t tok2;
    } plan_t;

    function automatic logic is_typo(tok_t tok);
        return (tok == TOK_EM) || (tok == TOK_EN) || (tok == TOK_LDQ) ||
               (tok == TOK_LSQ) || (tok == TOK_RDQ) || (tok == TOK_RSQ);
    endfunction

    function automatic logic [2:0] tok_len(tok_t tok, mode_t mode);
        logic [2:0] len;
        len = 3'd1;
        if (tok == TOK_NONE)
            len = 3'd0;
        else if (tok == TOK_RAW2)
            len = 3'd2;
        else if (is_typo(tok))
        begin
            if (mode == MODE_UTF8)
                len = 3'd3;
            else if (mode == MODE_HTML)
                len = 3'd7;
            else if (tok == TOK_EM)
                len = 3'd2;
            else
                len = 3'd1;
        end
        return len;
    endfunction

    function automatic logic [7:0] tok_byte(tok_t tok, mode_t mode, logic [2:0] idx,
                                            logic [7:0] lit);
        logic [55:0] ent;
        logic [55:0] sh;
        logic [7:0]  b;
        ent = "&mdash;";
        case (tok)
            TOK_EN:  ent = "&ndash;";
            TOK_LDQ: ent = "&ldquo;";
            TOK_LSQ: ent = "&lsquo;";
            TOK_RDQ: ent = "&rdquo;";
            TOK_RSQ: ent = "&rsquo;";
            default: ent = "&mdash;";
        endcase
        sh = ent >> (6'd8 * (6'd6 - {3'd0, idx}));
        b  = CH_DASH;
        case (tok)
            TOK_LIT:  b = lit;
            TOK_BQ:   b = CH_BQ;
            TOK_AP:   b = CH_AP;
            TOK_DASH: b = CH_DASH;
            TOK_RAW2: b = CH_DASH;
            default:
            begin
                if (mode == MODE_UTF8)
                begin
                    case (idx)
                        3'd0:    b = 8'hE2;
                        3'd1:    b = 8'h80;
                        default:
                        begin
                            case (tok)
                                TOK_EM:  b = 8'h94;
                                TOK_EN:  b = 8'h93;
                                TOK_LDQ: b = 8'h9C;
                                TOK_LSQ: b = 8'h98;
                                TOK_RDQ: b = 8'h9D;
                                default: b = 8'h99;
                            endcase
                        end
                    endcase
                end
                else if (mode == MODE_HTML)
                    b = sh[7:0];
                else if ((tok == TOK_LDQ) || (tok == TOK_RDQ))
                    b = CH_DQ;
                else if ((tok == TOK_LSQ) || (tok == TOK_RSQ))
                    b = CH_AP;
                else
                    b = CH_DASH;
            end
        endcase
        return b;
    endfunction

endpackage

@@ rtl/tpr_text_if.sv @@
// Input channel of the rewriter: one text byte and its last flag per transaction.
// No dependencies.
interface tpr_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink (input valid, input text_byte, input text_last, output ready);
endinterface

@@ rtl/tpr_out_if.sv @@
// Output channel of the rewriter: one rewritten byte and its flags per transaction.
// No dependencies.
interface tpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output run_last, output text_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input text_end,
                  output ready);
endinterface

@@ rtl/tpr_planner.sv @@
// Resolves one input byte against the held mark into at most two output tokens.
// Depends on tpr_pkg.
module tpr_planner (
    input  tpr_pkg::held_t held,
    input  tpr_pkg::mode_t mode,
    input  logic [7:0]     text_byte,
    input  logic           text_last,
    output tpr_pkg::plan_t plan,
    output tpr_pkg::held_t held_next
);
    import tpr_pkg::*;

    held_t held_eff;
    held_t held_mid;
    logic  fresh;
    tok_t  t1;
    tok_t  t2;

    always_comb
    begin
        held_eff = (held > HELD_A1) ? HELD_NONE : held;
        held_mid = HELD_NONE;
        fresh    = 1'b0;
        t1       = TOK_NONE;
        t2       = TOK_NONE;

        if (mode == MODE_PASS)
        begin
            case (held_eff)
                HELD_D1: t1 = TOK_DASH;
                HELD_D2: t1 = TOK_RAW2;
                HELD_B1: t1 = TOK_BQ;
                HELD_A1: t1 = TOK_AP;
                default: t1 = TOK_NONE;
            endcase
            t2 = TOK_LIT;
        end
        else
        begin
            case (held_eff)
                HELD_D1:
                begin
                    if (text_byte == CH_DASH)
                        held_mid = HELD_D2;
                    else
                    begin
                        t1    = TOK_DASH;
                        fresh = 1'b1;
                    end
                end
                HELD_D2:
                begin
                    t1    = (text_byte == CH_DASH) ? TOK_EM : TOK_EN;
                    fresh = (text_byte != CH_DASH);
                end
                HELD_B1:
                begin
                    t1    = (text_byte == CH_BQ) ? TOK_LDQ : TOK_LSQ;
                    fresh = (text_byte != CH_BQ);
                end
                HELD_A1:
                begin
                    t1    = (text_byte == CH_AP) ? TOK_RDQ : TOK_RSQ;
                    fresh = (text_byte != CH_AP);
                end
                default: fresh = 1'b1;
            endcase
            if (fresh)
            begin
                case (text_byte)
                    CH_DASH: held_mid = HELD_D1;
                    CH_BQ:   held_mid = HELD_B1;
                    CH_AP:   held_mid = HELD_A1;
                    default: t2 = TOK_LIT;
                endcase
            end
        end

        // end of text: whatever is still held is flushed into the free second slot
        held_next = held_mid;
        if (text_last)
        begin
            held_next = HELD_NONE;
            case (held_mid)
                HELD_D1: t2 = TOK_DASH;
                HELD_D2: t2 = TOK_EN;
                HELD_B1: t2 = TOK_LSQ;
                HELD_A1: t2 = TOK_RSQ;
                default: ;
            endcase
        end

        plan.tok1 = t1;
        plan.tok2 = t2;
    end

endmodule

@@ rtl/typographic_punctuation_rewriter.sv @@
// Typographic punctuation rewriter: dash and quote runs to typographic forms.
// The first output byte is registered, valid in the cycle after the input transaction; a held mark emits later.
// Throughput: one input per cycle for plain text while the output is ready; an item causing more than
// one output byte holds the input until the byte emitter has sent its last byte (up to 14 bytes).
// Reset: asynchronous, active low; clears the held mark and emitter, mode returns to UTF-8.
module typographic_punctuation_rewriter (
    input  logic           clk,
    input  logic           rst_n,
    tpr_text_if.sink       text_in,
    tpr_out_if.source      text_out,
    input  logic           cfg_we,
    input  tpr_pkg::mode_t cfg_data
);
    import tpr_pkg::*;

    mode_t      mode_reg;
    held_t      held_reg;
    held_t      held_next;
    plan_t      plan;

    logic       busy_reg;
    tok_t       cur_reg;
    tok_t       nxt_reg;
    logic [2:0] idx_reg;
    logic [7:0] lit_reg;
    mode_t      emode_reg;
    logic       last_reg;

    logic [2:0] cur_len;
    logic       tok_done;
    logic       run_done;
    logic       in_take;
    logic       out_take;
    logic       load;

    tpr_planner u_planner (
        .held      (held_reg),
        .mode      (mode_reg),
        .text_byte (text_in.text_byte),
        .text_last (text_in.text_last),
        .plan      (plan),
        .held_next (held_next)
    );

    assign cur_len  = tok_len(cur_reg, emode_reg);
    assign tok_done = (idx_reg == cur_len - 3'd1);
    assign run_done = tok_done && (nxt_reg == TOK_NONE);

    assign text_in.ready   = !busy_reg || (text_out.ready && run_done);
    assign in_take         = text_in.valid && text_in.ready;
    assign out_take        = text_out.valid && text_out.ready;
    assign load            = in_take && ((plan.tok1 != TOK_NONE) || (plan.tok2 != TOK_NONE));

    assign text_out.valid    = busy_reg;
    assign text_out.out_byte = tok_byte(cur_reg, emode_reg, idx_reg, lit_reg);
    assign text_out.run_last = run_done;
    assign text_out.text_end = run_done && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UTF8;
            held_reg <= HELD_NONE;
            busy_reg <= 1'b0;
            cur_reg  <= TOK_NONE;
            nxt_reg  <= TOK_NONE;
            idx_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (in_take)
                held_reg <= held_next;

            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 3'd0;
                // an empty first slot lets the second token move up
                if (plan.tok1 != TOK_NONE)
                begin
                    cur_reg <= plan.tok1;
                    nxt_reg <= plan.tok2;
                end
                else
                begin
                    cur_reg <= plan.tok2;
                    nxt_reg <= TOK_NONE;
                end
            end
            else if (out_take)
            begin
                if (!tok_done)
                    idx_reg <= idx_reg + 3'd1;
                else if (nxt_reg != TOK_NONE)
                begin
                    cur_reg <= nxt_reg;
                    nxt_reg <= TOK_NONE;
                    idx_reg <= 3'd0;
                end
                else
                    busy_reg <= 1'b0;
            end
        end
    end

    // payload of the emitter, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lit_reg   <= text_in.text_byte;
            emode_reg <= mode_reg;
            last_reg  <= text_in.text_last;
        end
    end

`ifndef SYNTH
    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        text_out.valid && text_out.text_end |-> text_out.run_last)
        else $error("text_end without run_last");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !text_out.valid |-> text_in.ready)
        else $error("input stalled with empty emitter");

    a_drain_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        text_out.valid && text_out.ready && text_out.run_last &&
        !(text_in.valid && text_in.ready) |=> !text_out.valid)
        else $error("output still valid after final byte of run");

    a_idx_in_token: assert property (@(posedge clk) disable iff (!rst_n)
        text_out.valid |-> (idx_reg < cur_len))
        else $error("byte index beyond token length");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for typographic_punctuation_rewriter: directed and random text
// through all four output modes, with bursty input, stalling output and a long back-pressure.
// Depends on rtl/tpr_pkg.sv, rtl/tpr_text_if.sv, rtl/tpr_out_if.sv and the rewriter RTL.
module tb;
    import tpr_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 38;

    typedef struct {
        logic [7:0] text_byte;
        logic       text_last;
    } text_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } out_beat_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    mode_t cfg_data;

    tpr_text_if text_if ();
    tpr_out_if  out_if ();

    typographic_punctuation_rewriter DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_if),
        .text_out (out_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    text_item_t pending_text[$];
    out_beat_t  expected_beats[$];
    logic [7:0] run_buf[$];
    int         queued_cnt   = 0;
    int         accepted_cnt = 0;
    int         err_count    = 0;

    // predictor state
    held_t mark_st = HELD_NONE;
    mode_t mode_st = MODE_UTF8;

    // pacing knobs, set by the stimulus process
    int   max_gap     = 0;
    int   stall_pct   = 0;
    int   stall_per   = 0;
    logic hold_req    = 1'b0;

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0h, want %0h", what, got, want);
        err_count++;
    endtask

    task automatic put_form(tok_t tok);
        string ent;
        int    i;
        if (tok == TOK_DASH)
            run_buf.push_back(CH_DASH);
        else if (mode_st == MODE_UTF8)
        begin
            run_buf.push_back(8'hE2);
            run_buf.push_back(8'h80);
            case (tok)
                TOK_EM:  run_buf.push_back(8'h94);
                TOK_EN:  run_buf.push_back(8'h93);
                TOK_LDQ: run_buf.push_back(8'h9C);
                TOK_LSQ: run_buf.push_back(8'h98);
                TOK_RDQ: run_buf.push_back(8'h9D);
                default: run_buf.push_back(8'h99);
            endcase
        end
        else if (mode_st == MODE_HTML)
        begin
            case (tok)
                TOK_EM:  ent = "&mdash;";
                TOK_EN:  ent = "&ndash;";
                TOK_LDQ: ent = "&ldquo;";
                TOK_LSQ: ent = "&lsquo;";
                TOK_RDQ: ent = "&rdquo;";
                default: ent = "&rsquo;";
            endcase
            for (i = 0; i < ent.len(); i++)
                run_buf.push_back(ent[i]);
        end
        else
        begin
            case (tok)
                TOK_EM:
                begin
                    run_buf.push_back(CH_DASH);
                    run_buf.push_back(CH_DASH);
                end
                TOK_EN:            run_buf.push_back(CH_DASH);
                TOK_LDQ, TOK_RDQ:  run_buf.push_back(CH_DQ);
                default:           run_buf.push_back(CH_AP);
            endcase
        end
    endtask

    task automatic start_fresh(logic [7:0] c);
        if (c == CH_DASH)
            mark_st = HELD_D1;
        else if (c == CH_BQ)
            mark_st = HELD_B1;
        else if (c == CH_AP)
            mark_st = HELD_A1;
        else
            run_buf.push_back(c);
    endtask

    task automatic flush_mark();
        if (mode_st == MODE_PASS)
        begin
            case (mark_st)
                HELD_D1: run_buf.push_back(CH_DASH);
                HELD_D2:
                begin
                    run_buf.push_back(CH_DASH);
                    run_buf.push_back(CH_DASH);
                end
                HELD_B1: run_buf.push_back(CH_BQ);
                HELD_A1: run_buf.push_back(CH_AP);
                default: ;
            endcase
        end
        else
        begin
            case (mark_st)
                HELD_D1: put_form(TOK_DASH);
                HELD_D2: put_form(TOK_EN);
                HELD_B1: put_form(TOK_LSQ);
                HELD_A1: put_form(TOK_RSQ);
                default: ;
            endcase
        end
        mark_st = HELD_NONE;
    endtask

    // Works out the output bytes of one accepted input transaction.
    task automatic rewrite_item(logic [7:0] c, logic last);
        out_beat_t beat;
        int        k;
        run_buf.delete();
        if (mark_st > HELD_A1)
            mark_st = HELD_NONE;
        if (mode_st == MODE_PASS)
        begin
            flush_mark();
            run_buf.push_back(c);
        end
        else
        begin
            case (mark_st)
                HELD_D1:
                begin
                    if (c == CH_DASH)
                        mark_st = HELD_D2;
                    else
                    begin
                        mark_st = HELD_NONE;
                        put_form(TOK_DASH);
                        start_fresh(c);
                    end
                end
                HELD_D2:
                begin
                    mark_st = HELD_NONE;
                    if (c == CH_DASH)
                        put_form(TOK_EM);
                    else
                    begin
                        put_form(TOK_EN);
                        start_fresh(c);
                    end
                end
                HELD_B1:
                begin
                    mark_st = HELD_NONE;
                    if (c == CH_BQ)
                        put_form(TOK_LDQ);
                    else
                    begin
                        put_form(TOK_LSQ);
                        start_fresh(c);
                    end
                end
                HELD_A1:
                begin
                    mark_st = HELD_NONE;
                    if (c == CH_AP)
                        put_form(TOK_RDQ);
                    else
                    begin
                        put_form(TOK_RSQ);
                        start_fresh(c);
                    end
                end
                default: start_fresh(c);
            endcase
        end
        if (last)
            flush_mark();
        for (k = 0; k < run_buf.size(); k++)
        begin
            beat.out_byte = run_buf[k];
            beat.run_last = (k == run_buf.size() - 1);
            beat.text_end = (k == run_buf.size() - 1) && last;
            expected_beats.push_back(beat);
        end
    endtask

    // Sender: bursts of random length with random gaps between them.
    int         burst_left = 0;
    int         gap_left   = 0;
    text_item_t next_item;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
            begin
                rewrite_item(text_if.text_byte, text_if.text_last);
                accepted_cnt++;
            end
            if (!text_if.valid || text_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    text_if.valid <= 1'b0;
                end
                else if (pending_text.size() > 0)
                begin
                    next_item = pending_text.pop_front();
                    text_if.valid     <= 1'b1;
                    text_if.text_byte <= next_item.text_byte;
                    text_if.text_last <= next_item.text_last;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
                    end
                    else
                        burst_left--;
                end
                else
                    text_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random and periodic stalls, plus a long hold-off on request.
    int   hold_left = 0;
    int   rx_cyc    = 0;
    logic hold_seen = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            rx_cyc++;
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= ($urandom_range(0, 99) >= stall_pct) &&
                                ((stall_per == 0) || (rx_cyc % stall_per != 0));
        end
    end

    // Output checker
    out_beat_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected byte", out_if.out_byte, 0);
            else
            begin
                want = expected_beats.pop_front();
                if (out_if.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_if.out_byte, want.out_byte);
                if (out_if.run_last !== want.run_last)
                    report_mismatch("run_last", out_if.run_last, want.run_last);
                if (out_if.text_end !== want.text_end)
                    report_mismatch("text_end", out_if.text_end, want.text_end);
            end
        end
    end

    task automatic add_byte(logic [7:0] b, logic last);
        text_item_t it;
        it.text_byte = b;
        it.text_last = last;
        pending_text.push_back(it);
        queued_cnt++;
    endtask

    task automatic add_str(string s, logic last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Punctuation-heavy byte mix so that runs of every length turn up.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: return CH_DASH;
            3:       return CH_BQ;
            4:       return CH_AP;
            5:       return CH_DQ;
            6:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random_text();
        int   len;
        int   i;
        logic noisy;
        logic cut;
        len   = $urandom_range(1, 10);
        noisy = ($urandom_range(0, 4) == 0);
        cut   = ($urandom_range(0, 7) == 0);   // text runs on into the next one
        for (i = 0; i < len; i++)
            add_byte(noisy ? 8'($urandom_range(0, 255)) : pick_byte(),
                     (i == len - 1) && !cut);
    endtask

    task automatic set_mode(mode_t m);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        mode_st = m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Held marks produce nothing until resolved, hence the tail after draining.
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int    ph;
        int    start_cnt;
        mode_t m;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = MODE_UTF8;
        text_if.valid     = 1'b0;
        text_if.text_byte = 8'h00;
        text_if.text_last = 1'b0;
        out_if.ready      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset mode first, no register write
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_str("---", 1'b0);
        add_str("--a", 1'b0);
        add_str("-b", 1'b0);
        add_byte(CH_BQ, 1'b0);
        add_byte(CH_BQ, 1'b0);
        add_byte(CH_BQ, 1'b0);
        add_str("c", 1'b0);
        add_str("''", 1'b0);
        add_str("'", 1'b1);
        add_str("--", 1'b0);       // en dash left pending across the mode change
        wait_idle();
        set_mode(MODE_HTML);
        add_str("x", 1'b0);
        add_byte(CH_BQ, 1'b1);
        wait_idle();
        set_mode(MODE_ASCII);
        add_str("---''-", 1'b0);   // lone dash pending into passthrough
        wait_idle();
        set_mode(MODE_PASS);
        add_byte(CH_BQ, 1'b1);
        wait_idle();

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       m = MODE_ASCII;
                1:       m = MODE_PASS;
                2:       m = MODE_HTML;
                3:       m = MODE_UTF8;
                default: m = mode_t'($urandom_range(0, 3));
            endcase
            set_mode(m);
            max_gap   <= (ph % 3 == 0) ? 0 : $urandom_range(1, 6);
            stall_pct <= (ph % 4 == 1) ? 0 : 20 * $urandom_range(0, 3);
            stall_per <= (ph % 2 == 0) ? $urandom_range(2, 5) : 0;
            if (ph == 2)
            begin
                max_gap  <= 0;
                hold_req <= ~hold_req;
            end
            start_cnt = queued_cnt;
            while (queued_cnt - start_cnt < PHASE_ITEMS)
                add_random_text();
            wait_idle();
        end

        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
